### rtl/core/cigar_pkg.sv
// Shared types, codes and the operation letter decoder for the CIGAR op word block.
`timescale 1ns / 1ps

package cigar_pkg;

  localparam int unsigned LenW   = 28;
  localparam int unsigned CountW = 16;
  localparam int unsigned CodeW  = 4;
  localparam int unsigned WordW  = LenW + CodeW;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OP_WORD   = 3'd0,
    ST_NO_CIGAR  = 3'd1,
    ST_BAD_CHAR  = 3'd2,
    ST_BAD_OP    = 3'd3,
    ST_DANGLING  = 3'd4
  } status_e;

  // Operation codes
  localparam logic [CodeW-1:0] OpMatch = 4'd0;
  localparam logic [CodeW-1:0] OpIns   = 4'd1;
  localparam logic [CodeW-1:0] OpDel   = 4'd2;
  localparam logic [CodeW-1:0] OpSkip  = 4'd3;
  localparam logic [CodeW-1:0] OpSoft  = 4'd4;
  localparam logic [CodeW-1:0] OpHard  = 4'd5;
  localparam logic [CodeW-1:0] OpPad   = 4'd6;

  typedef struct packed {
    logic             valid;
    logic [CodeW-1:0] code;
  } op_dec_t;

  // Upper-case a letter and map it to an operation code
  function automatic op_dec_t op_code_of(logic [7:0] c);
    logic [7:0] u;
    op_dec_t    r;
    u = c;
    if (c >= 8'h61 && c <= 8'h7a) begin
      u = c & 8'hdf;
    end
    r.valid = 1'b1;
    r.code  = OpMatch;
    case (u) inside
      "M", "=", "X": r.code = OpMatch;
      "I":           r.code = OpIns;
      "D":           r.code = OpDel;
      "N":           r.code = OpSkip;
      "S":           r.code = OpSoft;
      "H":           r.code = OpHard;
      "P":           r.code = OpPad;
      default:       r.valid = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic is_letter(logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5a) || (c >= 8'h61 && c <= 8'h7a);
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

endpackage

### rtl/core/cigar_string_to_op_words.sv
// Top level: CIGAR text stream in, packed operation words out.
`timescale 1ns / 1ps

// Takes one CIGAR character per beat and returns one packed word (length in
// bits 31..4, op code in bits 3..0) for every operation letter before the
// first error, with its index in the string. The final character of a string
// (end_of_string_i) always yields exactly one result with last_o set: its own
// op word, the no-CIGAR report for a lone '*', or the first error seen in the
// string, in which case earlier words of that string must be dropped
// downstream. Characters that end no operation give no result. A character
// passes the input register, then the result register; one is accepted every
// cycle as long as the result side keeps taking beats, since the length update
// is a single multiply-by-ten and add in the stage between the two registers.
module cigar_string_to_op_words
  import cigar_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        char_code_i,
  input  logic              end_of_string_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [WordW-1:0]  op_word_o,
  output logic [CountW-1:0] op_index_o,
  output logic [2:0]        status_o,
  output logic              last_o
);

  // Input register
  logic       s1_valid_q;
  logic [7:0] s1_char_q;
  logic       s1_eos_q;

  // String state
  logic [LenW-1:0]   len_q, len_d;
  logic [CountW-1:0] count_q, count_d;
  logic              first_q, first_d;
  logic              star_q, star_d;
  status_e           err_q, err_d;

  // Result register
  logic              out_valid_q;
  logic [WordW-1:0]  word_q, word_d;
  logic [CountW-1:0] index_q, index_d;
  status_e           status_q, status_d;
  logic              last_q;

  logic    emit_op, needs_out, out_free, s1_go;
  status_e err_cur;
  op_dec_t dec;

  assign out_free   = !out_valid_q || out_ready_i;
  assign needs_out  = emit_op || s1_eos_q;
  assign s1_go      = s1_valid_q && (!needs_out || out_free);
  assign in_ready_o = !s1_valid_q || s1_go;

  // Character decode and state update
  always_comb begin
    dec      = op_code_of(s1_char_q);
    err_cur  = (err_q == ST_OP_WORD && star_q) ? ST_BAD_CHAR : err_q;
    len_d    = len_q;
    count_d  = count_q;
    star_d   = star_q;
    err_d    = err_cur;
    first_d  = 1'b0;
    emit_op  = 1'b0;
    word_d   = '0;
    index_d  = '0;
    status_d = ST_OP_WORD;

    if (err_cur == ST_OP_WORD) begin
      if (first_q && s1_char_q == "*") begin
        star_d = 1'b1;
      end else if (is_digit(s1_char_q)) begin
        // len * 10 + digit, low bits kept
        len_d = (len_q << 3) + (len_q << 1) + LenW'(s1_char_q - 8'h30);
      end else if (dec.valid) begin
        emit_op = 1'b1;
        word_d  = {len_q, dec.code};
        index_d = count_q;
        if (count_q != {CountW{1'b1}}) begin
          count_d = count_q + 1'b1;
        end
        len_d = '0;
      end else if (is_letter(s1_char_q)) begin
        err_d = ST_BAD_OP;
      end else begin
        err_d = ST_BAD_CHAR;
      end
    end

    // Closing beat of a string
    if (s1_eos_q) begin
      if (!emit_op) begin
        if (err_d != ST_OP_WORD) begin
          status_d = err_d;
        end else if (star_d) begin
          status_d = ST_NO_CIGAR;
        end else begin
          status_d = ST_DANGLING;
        end
      end
      len_d   = '0;
      count_d = '0;
      star_d  = 1'b0;
      err_d   = ST_OP_WORD;
      first_d = 1'b1;
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_char_q <= char_code_i;
      s1_eos_q  <= end_of_string_i;
    end
  end

  // String state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q   <= '0;
      count_q <= '0;
      first_q <= 1'b1;
      star_q  <= 1'b0;
      err_q   <= ST_OP_WORD;
    end else if (s1_go) begin
      len_q   <= len_d;
      count_q <= count_d;
      first_q <= first_d;
      star_q  <= star_d;
      err_q   <= err_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_go && needs_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && needs_out) begin
      word_q   <= word_d;
      index_q  <= index_d;
      status_q <= status_d;
      last_q   <= s1_eos_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign op_word_o   = word_q;
  assign op_index_o  = index_q;
  assign status_o    = status_q;
  assign last_o      = last_q;

endmodule

### tb/tb.sv
// Self-checking testbench for the CIGAR text to packed op word converter.
`timescale 1ns / 1ps

module tb
  import cigar_pkg::*;
();

  // Expected result beat
  typedef struct packed {
    logic [WordW-1:0]  word;
    logic [CountW-1:0] index;
    status_e           st;
    logic              last;
  } op_result_t;

  // Directed stimulus row; typed rows carry their own expected result
  typedef struct packed {
    logic [7:0]       c;
    logic             eos;
    logic             typed;
    logic [WordW-1:0] word;
    status_e          st;
  } dir_row_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [7:0]        char_code_i = 8'h00;
  logic              end_of_string_i = 1'b0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [WordW-1:0]  op_word_o;
  logic [CountW-1:0] op_index_o;
  logic [2:0]        status_o;
  logic              last_o;

  // Predictor state for the string in progress
  logic [LenW-1:0]   len_acc;
  logic [CountW-1:0] op_cnt;
  logic              first_char;
  logic              star_flag;
  status_e           err_code;

  op_result_t  expected_words[$];
  dir_row_t    dir_rows[$];
  logic [7:0]  str_chars[$];
  string       op_letters = "MIDNSHP=Xmidnshpx";
  int          errors = 0;
  int          beats_sent = 0;
  int          idle_pct = 0;
  int          stall_pct = 0;

  cigar_string_to_op_words dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .char_code_i     (char_code_i),
    .end_of_string_i (end_of_string_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .op_word_o       (op_word_o),
    .op_index_o      (op_index_o),
    .status_o        (status_o),
    .last_o          (last_o)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    #20000000;
    $display("tb: done, errors");
    $finish;
  end

  // Op letter to code, -1 when the letter names no operation
  function automatic int op_code_for(input logic [7:0] c);
    logic [7:0] u;
    u = (c >= "a" && c <= "z") ? c - 8'd32 : c;
    case (u)
      "M", "=", "X": return OpMatch;
      "I":           return OpIns;
      "D":           return OpDel;
      "N":           return OpSkip;
      "S":           return OpSoft;
      "H":           return OpHard;
      "P":           return OpPad;
      default:       return -1;
    endcase
  endfunction

  task automatic clear_string_state();
    len_acc    = '0;
    op_cnt     = '0;
    first_char = 1'b1;
    star_flag  = 1'b0;
    err_code   = ST_OP_WORD;
  endtask

  // Advance the predictor by one character
  task automatic predict_beat(input logic [7:0] c, input logic eos,
                              output bit got, output op_result_t r);
    int code;
    got = 1'b0;
    r   = '0;
    // anything after a leading star spoils the no-CIGAR mark
    if (err_code == ST_OP_WORD && star_flag) err_code = ST_BAD_CHAR;
    if (err_code == ST_OP_WORD) begin
      if (first_char && c == "*") begin
        star_flag = 1'b1;
      end else if (c >= "0" && c <= "9") begin
        len_acc = LenW'(len_acc * 10 + (c - "0"));
      end else begin
        code = op_code_for(c);
        if (code >= 0) begin
          r.word  = {len_acc, code[CodeW-1:0]};
          r.index = op_cnt;
          r.st    = ST_OP_WORD;
          got     = 1'b1;
          if (op_cnt != '1) op_cnt = op_cnt + 1'b1;
          len_acc = '0;
        end else if ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z")) begin
          err_code = ST_BAD_OP;
        end else begin
          err_code = ST_BAD_CHAR;
        end
      end
    end
    first_char = 1'b0;
    // closing beat: op word, star report or first error
    if (eos) begin
      if (!got) begin
        if (err_code != ST_OP_WORD) r.st = err_code;
        else if (star_flag)         r.st = ST_NO_CIGAR;
        else                        r.st = ST_DANGLING;
        got = 1'b1;
      end
      r.last = 1'b1;
      clear_string_state();
    end
  endtask

  // Present one character and wait for its beat to be taken
  task automatic put_char(input logic [7:0] c, input logic eos);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    char_code_i     <= c;
    end_of_string_i <= eos;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    beats_sent++;
  endtask

  task automatic feed_char(input logic [7:0] c, input logic eos);
    bit         got;
    op_result_t r;
    put_char(c, eos);
    predict_beat(c, eos, got, r);
    if (got) expected_words.push_back(r);
  endtask

  task automatic add_row(input logic [7:0] c, input logic eos, input logic typed,
                         input logic [WordW-1:0] word, input status_e st);
    dir_row_t row;
    row.c     = c;
    row.eos   = eos;
    row.typed = typed;
    row.word  = word;
    row.st    = st;
    dir_rows.push_back(row);
  endtask

  // One operation: optional decimal length, then an op letter
  task automatic add_op();
    int pick;
    int ndig;
    pick = $urandom_range(99);
    if (pick < 15)      ndig = 0;
    else if (pick < 85) ndig = $urandom_range(3, 1);
    else                ndig = $urandom_range(12, 4);
    repeat (ndig) str_chars.push_back(8'(8'h30 + $urandom_range(9)));
    str_chars.push_back(op_letters[$urandom_range(op_letters.len() - 1)]);
  endtask

  // Build one random string: mostly well formed, the rest broken or noise
  task automatic make_string();
    int pick;
    int n;
    str_chars.delete();
    pick = $urandom_range(99);
    if (pick < 8) begin
      str_chars.push_back("*");
    end else if (pick < 13) begin
      n = $urandom_range(8, 1);
      if ($urandom_range(1)) str_chars.push_back("*");
      repeat (n) str_chars.push_back(8'($urandom_range(255)));
    end else begin
      n = $urandom_range(6, 1);
      repeat (n) add_op();
      if (pick < 23) begin
        repeat ($urandom_range(3, 1)) str_chars.push_back(8'(8'h30 + $urandom_range(9)));
      end else if (pick < 31) begin
        str_chars[$urandom_range(str_chars.size() - 1)] = 8'($urandom_range(255));
      end else if (pick < 37) begin
        str_chars[$urandom_range(str_chars.size() - 1)] =
          8'($urandom_range(1) ? 8'h41 + $urandom_range(25) : 8'h61 + $urandom_range(25));
      end
    end
  endtask

  task automatic send_string();
    for (int i = 0; i < str_chars.size(); i++) begin
      feed_char(str_chars[i], i == str_chars.size() - 1);
    end
  endtask

  // Compare one result beat against the oldest expectation
  task automatic check_result();
    op_result_t want;
    if (expected_words.size() == 0) begin
      $display("%0t: unexpected beat word=%h index=%0d status=%0d last=%b",
               $time, op_word_o, op_index_o, status_o, last_o);
      errors++;
    end else begin
      want = expected_words.pop_front();
      if (op_word_o !== want.word) begin
        $display("%0t: op_word expected %h got %h", $time, want.word, op_word_o);
        errors++;
      end
      if (op_index_o !== want.index) begin
        $display("%0t: op_index expected %0d got %0d", $time, want.index, op_index_o);
        errors++;
      end
      if (status_o !== want.st) begin
        $display("%0t: status expected %0d got %0d", $time, want.st, status_o);
        errors++;
      end
      if (last_o !== want.last) begin
        $display("%0t: last expected %b got %b", $time, want.last, last_o);
        errors++;
      end
    end
  endtask

  // Result side: check taken beats, stall at random
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) check_result();
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    int         goal;
    bit         got;
    op_result_t r;
    op_result_t typed_r;
    clear_string_state();

    // lone star, bare letter, bad bytes, trailing digit, unknown letter
    add_row("*",   1'b1, 1'b1, '0, ST_NO_CIGAR);
    add_row("M",   1'b1, 1'b1, '0, ST_OP_WORD);
    add_row(8'h00, 1'b1, 1'b1, '0, ST_BAD_CHAR);
    add_row(8'hff, 1'b1, 1'b1, '0, ST_BAD_CHAR);
    add_row("5",   1'b1, 1'b1, '0, ST_DANGLING);
    add_row("q",   1'b1, 1'b1, '0, ST_BAD_OP);
    // star followed by more text
    add_row("*",   1'b0, 1'b1, '0, ST_OP_WORD);
    add_row("M",   1'b1, 1'b1, '0, ST_BAD_CHAR);
    // every op letter but M, both cases, equals sign
    add_row("1",   1'b0, 1'b0, '0, ST_OP_WORD);
    add_row("2",   1'b0, 1'b0, '0, ST_OP_WORD);
    add_row("i",   1'b0, 1'b0, '0, ST_OP_WORD);
    add_row("=",   1'b0, 1'b0, '0, ST_OP_WORD);
    add_row("x",   1'b0, 1'b0, '0, ST_OP_WORD);
    add_row("d",   1'b0, 1'b0, '0, ST_OP_WORD);
    add_row("n",   1'b0, 1'b0, '0, ST_OP_WORD);
    add_row("s",   1'b0, 1'b0, '0, ST_OP_WORD);
    add_row("h",   1'b0, 1'b0, '0, ST_OP_WORD);
    add_row("P",   1'b1, 1'b0, '0, ST_OP_WORD);
    // error mid-string, later ops suppressed, first error wins
    add_row("3",   1'b0, 1'b1, '0, ST_OP_WORD);
    add_row("Z",   1'b0, 1'b1, '0, ST_OP_WORD);
    add_row("%",   1'b0, 1'b1, '0, ST_OP_WORD);
    add_row("4",   1'b0, 1'b1, '0, ST_OP_WORD);
    add_row("M",   1'b1, 1'b1, '0, ST_BAD_OP);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    foreach (dir_rows[i]) begin
      put_char(dir_rows[i].c, dir_rows[i].eos);
      predict_beat(dir_rows[i].c, dir_rows[i].eos, got, r);
      if (dir_rows[i].typed) begin
        if (dir_rows[i].eos) begin
          typed_r.word  = dir_rows[i].word;
          typed_r.index = '0;
          typed_r.st    = dir_rows[i].st;
          typed_r.last  = 1'b1;
          expected_words.push_back(typed_r);
        end
      end else if (got) begin
        expected_words.push_back(r);
      end
    end

    // random strings under each idling pattern
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 71; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 71; end
        default: begin idle_pct = 25; stall_pct = 25; end
      endcase
      goal = beats_sent + 175;
      while (beats_sent < goal) begin
        make_string();
        send_string();
      end
    end
    in_valid_i <= 1'b0;

    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
